/* src/svpwm_pkg.sv */
package svpwm_pkg;

   // Defaults for the top-level parameters.
   localparam int ANGLE_BITS_DEFAULT = 16;
   localparam int SINE_ENTRIES_DEFAULT = 1024;

   // Field widths on the ports.
   localparam int CMD_W = 16;
   localparam int ANGLE_IN_W = 16;
   localparam int MOTOR_W = 2;
   localparam int DUTY_W = 16;
   localparam int CFG_W = 16;
   localparam int CSR_INDEX_W = 2;

   // Internal datapath widths.
   localparam int K_W = 31;
   localparam int MP_W = 32;
   localparam int PROD_W = 63;
   localparam int Q_FRAC = 30;
   localparam int TIME_W = 32;
   localparam int IDX_IN_W = 16;
   localparam int SUM_W = TIME_W + 3;

   // Divider organization: quotient bits retired per pipeline stage.
   localparam int DIV_BITS_PER_STAGE = 4;
   localparam int DIV_STAGES = TIME_W / DIV_BITS_PER_STAGE;

   // Fixed-point constants in Q30.
   localparam logic [63:0] SQRT3_Q30 = 64'd1859775393;
   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

   // Register reset values.
   localparam logic [CFG_W-1:0] SUPPLY_RESET = 16'd12000;
   localparam logic [CFG_W-1:0] PERIOD_RESET = 16'd4000;

   // Motor numbers that select a bridge.
   localparam logic [MOTOR_W-1:0] MOTOR_ONE = 2'd1;
   localparam logic [MOTOR_W-1:0] MOTOR_TWO = 2'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SUPPLY_VOLTAGE = 2'd0,
      REG_PWM_PERIOD     = 2'd1
   } reg_index_type;

   typedef enum logic [2:0] {
      SECTOR_1 = 3'd0,
      SECTOR_2 = 3'd1,
      SECTOR_3 = 3'd2,
      SECTOR_4 = 3'd3,
      SECTOR_5 = 3'd4,
      SECTOR_6 = 3'd5
   } sector_type;

   // Side information that rides along with every item.
   typedef struct packed {
      logic       bridge;
      sector_type sector;
   } tag_type;

   // Dividends for the two active times, already shifted down by Q_FRAC.
   typedef struct packed {
      tag_type             tag;
      logic [TIME_W-1:0]   num1;
      logic [TIME_W-1:0]   num2;
   } div_in_type;

   // Active times T1 and T2 in timer counts.
   typedef struct packed {
      tag_type             tag;
      logic [TIME_W-1:0]   t1;
      logic [TIME_W-1:0]   t2;
   } times_type;

   // sqrt3 * sin(x) in Q30 for an angle x in Q30 radians (series to x^11).
   // Only evaluated at elaboration to build the constant table.
   function automatic logic [K_W-1:0] svpwm_k_of_x(input logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        sn;
      logic [63:0]        prod;
      x2 = (x * x) >> 30;
      term = x;
      sum = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum = sum - $signed(term);
      sn = (sum < 0) ? 64'd0 : $unsigned(sum);
      prod = (SQRT3_Q30 * sn) >> 30;
      return prod[K_W-1:0];
   endfunction

   // Division by three through a reciprocal multiply; exact below 2^16.
   function automatic logic [IDX_IN_W-1:0] svpwm_div3(input logic [IDX_IN_W-1:0] y);
      logic [IDX_IN_W+16:0] p;
      p = (IDX_IN_W + 17)'(y) * (IDX_IN_W + 17)'(43691);
      return p[IDX_IN_W+16:17];
   endfunction

endpackage

/* src/svpwm_front.sv */
module svpwm_front #(
   parameter int ANGLE_BITS = svpwm_pkg::ANGLE_BITS_DEFAULT,
   parameter int SINE_TABLE_ENTRIES = svpwm_pkg::SINE_ENTRIES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic signed [svpwm_pkg::CMD_W-1:0]    in_cmd,
   input  logic [svpwm_pkg::ANGLE_IN_W-1:0]      in_angle,
   input  logic [svpwm_pkg::MOTOR_W-1:0]         in_motor,
   input  logic [svpwm_pkg::CFG_W-1:0]           period,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output svpwm_pkg::div_in_type                 out_item
);
   import svpwm_pkg::*;

   localparam int AW = ANGLE_BITS;
   localparam int EXT_W = (AW > ANGLE_IN_W) ? AW : ANGLE_IN_W;
   localparam int N_W = $clog2(SINE_TABLE_ENTRIES + 1);
   localparam int X_W = AW + 1 + N_W;
   localparam int K_ENTRIES = SINE_TABLE_ENTRIES / 6 + 1;
   localparam int IDX_W = $clog2(K_ENTRIES);
   localparam int K_DEPTH = 2 ** IDX_W;
   localparam int STAGES = 5;
   localparam int LAST = STAGES - 1;

   // Handshake state of the five stages.
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] valid_src;
   logic [STAGES-1:0] stage_ready;
   tag_type           tag_ff [STAGES];
   tag_type           tag_in [STAGES];

   // Stage one: angle and magnitude.
   logic [EXT_W-1:0]  angle_ext;
   logic [AW-1:0]     angle_rs;
   logic [AW-1:0]     angle_n;
   logic [AW+2:0]     a6;
   logic              neg;
   logic              motor_ok;
   logic [CMD_W-1:0]  s1_mag_in, s1_mag_ff;
   logic [AW-1:0]     s1_r_in, s1_r_ff;

   // Stage two: scaled table positions and mag * period.
   logic [AW:0]            rn1;
   logic [X_W-1:0]         x1, x2;
   logic [IDX_IN_W-1:0]    s2_y1_in, s2_y1_ff, s2_y2_in, s2_y2_ff;
   logic [MP_W-1:0]        s2_mp_in, s2_mp_ff;

   // Stage three: table indexes.
   logic [IDX_W-1:0]       s3_i1_in, s3_i1_ff, s3_i2_in, s3_i2_ff;
   logic [MP_W-1:0]        s3_mp_ff;

   // Stage four: table values.
   logic [K_W-1:0]         k_rom [K_DEPTH];
   logic [K_W-1:0]         s4_k1_in, s4_k1_ff, s4_k2_in, s4_k2_ff;
   logic [MP_W-1:0]        s4_mp_ff;

   // Stage five: products.
   logic [PROD_W-1:0]      prod1, prod2;
   logic [TIME_W-1:0]      s5_num1_in, s5_num1_ff, s5_num2_in, s5_num2_ff;

   // Constant table of sqrt3 * sin over the first sixth of a turn.
   for (genvar gi = 0; gi < K_DEPTH; gi++) begin : g_ktab
      localparam logic [63:0] XQ =
         (64'(gi) * TWO_PI_Q30) / 64'(SINE_TABLE_ENTRIES);
      localparam logic [K_W-1:0] KV = svpwm_k_of_x(XQ);
      assign k_rom[gi] = KV;
   end

   // Resize the angle to the internal angle width.
   assign angle_ext = EXT_W'(in_angle);
   if (AW >= ANGLE_IN_W) begin : g_widen
      assign angle_rs = AW'(angle_ext << (AW - ANGLE_IN_W));
   end else begin : g_narrow
      assign angle_rs = AW'(angle_ext >> (ANGLE_IN_W - AW));
   end

   // A negative command turns the vector by half a turn.
   always_comb begin
      neg = in_cmd[CMD_W-1];
      s1_mag_in = neg ? CMD_W'(-in_cmd) : CMD_W'(in_cmd);
      angle_n = angle_rs ^ {neg, {(AW - 1){1'b0}}};
      a6 = ((AW + 3)'(angle_n) << 2) + ((AW + 3)'(angle_n) << 1);
      s1_r_in = a6[AW-1:0];
      motor_ok = (in_motor == MOTOR_ONE) || (in_motor == MOTOR_TWO);
   end

   // Table positions: floor(r * N / (6 * 2^AW)) as a shift and a divide by three.
   always_comb begin
      rn1 = (AW + 1)'(2 ** AW) - (AW + 1)'(s1_r_ff);
      x1 = X_W'(rn1) * X_W'(SINE_TABLE_ENTRIES);
      x2 = X_W'(s1_r_ff) * X_W'(SINE_TABLE_ENTRIES);
      s2_y1_in = IDX_IN_W'(x1 >> (AW + 1));
      s2_y2_in = IDX_IN_W'(x2 >> (AW + 1));
      s2_mp_in = MP_W'(s1_mag_ff) * MP_W'(period);
      s3_i1_in = IDX_W'(svpwm_div3(s2_y1_ff));
      s3_i2_in = IDX_W'(svpwm_div3(s2_y2_ff));
      s4_k1_in = k_rom[s3_i1_ff];
      s4_k2_in = k_rom[s3_i2_ff];
      prod1 = PROD_W'(s4_k1_ff) * PROD_W'(s4_mp_ff);
      prod2 = PROD_W'(s4_k2_ff) * PROD_W'(s4_mp_ff);
      s5_num1_in = prod1[Q_FRAC+TIME_W-1:Q_FRAC];
      s5_num2_in = prod2[Q_FRAC+TIME_W-1:Q_FRAC];
   end

   // Stage ready chain: a stage moves when it is empty or its successor moves.
   always_comb begin
      stage_ready[LAST] = !valid_ff[LAST] || out_ready;
      for (int s = LAST - 1; s >= 0; s--) begin
         stage_ready[s] = !valid_ff[s] || stage_ready[s + 1];
      end
   end

   // Valid bits and tags; motor numbers 0 and 3 are accepted and dropped.
   always_comb begin
      valid_src = {valid_ff[LAST-1:0], in_valid && motor_ok};
      tag_in[0].bridge = (in_motor == MOTOR_TWO);
      tag_in[0].sector = sector_type'(a6[AW+2:AW]);
      for (int s = 1; s < STAGES; s++) begin
         tag_in[s] = tag_ff[s - 1];
      end
      for (int s = 0; s < STAGES; s++) begin
         valid_in[s] = stage_ready[s] ? valid_src[s] : valid_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         if (stage_ready[s]) begin
            tag_ff[s] <= tag_in[s];
         end
      end
      if (stage_ready[0]) begin
         s1_mag_ff <= s1_mag_in;
         s1_r_ff <= s1_r_in;
      end
      if (stage_ready[1]) begin
         s2_y1_ff <= s2_y1_in;
         s2_y2_ff <= s2_y2_in;
         s2_mp_ff <= s2_mp_in;
      end
      if (stage_ready[2]) begin
         s3_i1_ff <= s3_i1_in;
         s3_i2_ff <= s3_i2_in;
         s3_mp_ff <= s2_mp_ff;
      end
      if (stage_ready[3]) begin
         s4_k1_ff <= s4_k1_in;
         s4_k2_ff <= s4_k2_in;
         s4_mp_ff <= s3_mp_ff;
      end
      if (stage_ready[4]) begin
         s5_num1_ff <= s5_num1_in;
         s5_num2_ff <= s5_num2_in;
      end
   end

   assign in_ready = stage_ready[0];
   assign out_valid = valid_ff[LAST];
   assign out_item.tag = tag_ff[LAST];
   assign out_item.num1 = s5_num1_ff;
   assign out_item.num2 = s5_num2_ff;

   // Table indexes never pass the sixth of a turn.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> (s3_i1_ff <= IDX_W'(K_ENTRIES - 1)) &&
                      (s3_i2_ff <= IDX_W'(K_ENTRIES - 1)))
      else $error("sine table index beyond the first sixth of a turn");

endmodule

/* src/svpwm_div.sv */
module svpwm_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  svpwm_pkg::div_in_type       in_item,
   input  logic [svpwm_pkg::CFG_W-1:0] divisor,
   output logic                        out_valid,
   input  logic                        out_ready,
   output svpwm_pkg::times_type        out_item
);
   import svpwm_pkg::*;

   localparam int LAST = DIV_STAGES - 1;

   logic [DIV_STAGES-1:0] valid_ff;
   logic [DIV_STAGES-1:0] valid_in;
   logic [DIV_STAGES-1:0] valid_src;
   logic [DIV_STAGES-1:0] stage_ready;

   tag_type               tag_ff [DIV_STAGES];
   tag_type               tag_in [DIV_STAGES];
   logic [TIME_W-1:0]     num1_ff [DIV_STAGES];
   logic [TIME_W-1:0]     num2_ff [DIV_STAGES];
   logic [CFG_W-1:0]      rem1_ff [DIV_STAGES];
   logic [CFG_W-1:0]      rem2_ff [DIV_STAGES];
   logic [TIME_W-1:0]     num1_src [DIV_STAGES];
   logic [TIME_W-1:0]     num2_src [DIV_STAGES];
   logic [CFG_W-1:0]      rem1_src [DIV_STAGES];
   logic [CFG_W-1:0]      rem2_src [DIV_STAGES];
   logic [CFG_W+TIME_W-1:0] step1_in [DIV_STAGES];
   logic [CFG_W+TIME_W-1:0] step2_in [DIV_STAGES];

   // Restoring division, a few quotient bits per call. Dividend bits leave
   // the top of num while quotient bits enter at the bottom.
   function automatic logic [CFG_W+TIME_W-1:0] div_steps(
      input logic [TIME_W-1:0] num,
      input logic [CFG_W-1:0]  rem,
      input logic [CFG_W-1:0]  dvs
   );
      logic [TIME_W-1:0] n;
      logic [CFG_W-1:0]  r;
      logic [CFG_W:0]    trial;
      n = num;
      r = rem;
      for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
         trial = {r, n[TIME_W-1]};
         if (trial >= {1'b0, dvs}) begin
            r = CFG_W'(trial - {1'b0, dvs});
            n = {n[TIME_W-2:0], 1'b1};
         end else begin
            r = trial[CFG_W-1:0];
            n = {n[TIME_W-2:0], 1'b0};
         end
      end
      return {r, n};
   endfunction

   // Stage inputs: the first stage takes the new beat with a zero remainder.
   always_comb begin
      valid_src = {valid_ff[LAST-1:0], in_valid};
      tag_in[0] = in_item.tag;
      num1_src[0] = in_item.num1;
      num2_src[0] = in_item.num2;
      rem1_src[0] = '0;
      rem2_src[0] = '0;
      for (int s = 1; s < DIV_STAGES; s++) begin
         tag_in[s] = tag_ff[s - 1];
         num1_src[s] = num1_ff[s - 1];
         num2_src[s] = num2_ff[s - 1];
         rem1_src[s] = rem1_ff[s - 1];
         rem2_src[s] = rem2_ff[s - 1];
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
         step1_in[s] = div_steps(num1_src[s], rem1_src[s], divisor);
         step2_in[s] = div_steps(num2_src[s], rem2_src[s], divisor);
      end
   end

   // Stage ready chain.
   always_comb begin
      stage_ready[LAST] = !valid_ff[LAST] || out_ready;
      for (int s = LAST - 1; s >= 0; s--) begin
         stage_ready[s] = !valid_ff[s] || stage_ready[s + 1];
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
         valid_in[s] = stage_ready[s] ? valid_src[s] : valid_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (stage_ready[s]) begin
            tag_ff[s] <= tag_in[s];
            num1_ff[s] <= step1_in[s][TIME_W-1:0];
            rem1_ff[s] <= step1_in[s][CFG_W+TIME_W-1:TIME_W];
            num2_ff[s] <= step2_in[s][TIME_W-1:0];
            rem2_ff[s] <= step2_in[s][CFG_W+TIME_W-1:TIME_W];
         end
      end
   end

   assign in_ready = stage_ready[0];
   assign out_valid = valid_ff[LAST];
   assign out_item.tag = tag_ff[LAST];
   assign out_item.t1 = num1_ff[LAST];
   assign out_item.t2 = num2_ff[LAST];

   // A finished division leaves a remainder below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST] |-> (rem1_ff[LAST] < divisor) && (rem2_ff[LAST] < divisor))
      else $error("divider remainder not below the divisor");

endmodule

/* src/svpwm_mix.sv */
module svpwm_mix (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  svpwm_pkg::times_type         in_item,
   input  logic [svpwm_pkg::CFG_W-1:0]  period,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [svpwm_pkg::DUTY_W-1:0] out_duty_a,
   output logic [svpwm_pkg::DUTY_W-1:0] out_duty_b,
   output logic [svpwm_pkg::DUTY_W-1:0] out_duty_c,
   output logic                         out_bridge
);
   import svpwm_pkg::*;

   localparam int STAGES = 3;
   localparam int LAST = STAGES - 1;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] valid_src;
   logic [STAGES-1:0] stage_ready;
   tag_type           tag_ff [STAGES];
   tag_type           tag_in [STAGES];

   // Stage one: zero time and its centered half.
   logic [TIME_W:0]          s12_in, s12_ff;
   logic signed [SUM_W-1:0]  t0;
   logic signed [SUM_W-1:0]  half_in, half_ff;
   logic [TIME_W-1:0]        t1_ff, t2_ff;

   // Stage two: raw compare values per sector.
   logic signed [SUM_W-1:0]  a12, a1, a2;
   logic signed [SUM_W-1:0]  raw_a_in, raw_a_ff;
   logic signed [SUM_W-1:0]  raw_b_in, raw_b_ff;
   logic signed [SUM_W-1:0]  raw_c_in, raw_c_ff;

   // Stage three: clamped outputs.
   logic [DUTY_W-1:0]        duty_a_in, duty_a_ff;
   logic [DUTY_W-1:0]        duty_b_in, duty_b_ff;
   logic [DUTY_W-1:0]        duty_c_in, duty_c_ff;

   function automatic logic [DUTY_W-1:0] clamp_duty(
      input logic signed [SUM_W-1:0] v,
      input logic [CFG_W-1:0]        p
   );
      logic signed [SUM_W-1:0] ps;
      ps = $signed(SUM_W'(p));
      if (v < 0) begin
         return '0;
      end else if (v > ps) begin
         return DUTY_W'(p);
      end else begin
         return v[DUTY_W-1:0];
      end
   endfunction

   // T0 = period - T1 - T2, halved with rounding toward minus infinity.
   always_comb begin
      s12_in = (TIME_W + 1)'(in_item.t1) + (TIME_W + 1)'(in_item.t2);
      t0 = $signed(SUM_W'(period)) - $signed(SUM_W'(s12_in));
      half_in = t0 >>> 1;
   end

   // The sector decides which sums feed the three phases.
   always_comb begin
      a12 = $signed(SUM_W'(s12_ff)) + half_ff;
      a1 = $signed(SUM_W'(t1_ff)) + half_ff;
      a2 = $signed(SUM_W'(t2_ff)) + half_ff;
      case (tag_ff[0].sector)
         SECTOR_1: begin
            raw_a_in = a12; raw_b_in = a2; raw_c_in = half_ff;
         end
         SECTOR_2: begin
            raw_a_in = a1; raw_b_in = a12; raw_c_in = half_ff;
         end
         SECTOR_3: begin
            raw_a_in = half_ff; raw_b_in = a12; raw_c_in = a2;
         end
         SECTOR_4: begin
            raw_a_in = half_ff; raw_b_in = a1; raw_c_in = a12;
         end
         SECTOR_5: begin
            raw_a_in = a2; raw_b_in = half_ff; raw_c_in = a12;
         end
         SECTOR_6: begin
            raw_a_in = a12; raw_b_in = half_ff; raw_c_in = a1;
         end
         default: begin
            raw_a_in = a12; raw_b_in = half_ff; raw_c_in = a1;
         end
      endcase
   end

   // Saturate to 0..period.
   always_comb begin
      duty_a_in = clamp_duty(raw_a_ff, period);
      duty_b_in = clamp_duty(raw_b_ff, period);
      duty_c_in = clamp_duty(raw_c_ff, period);
   end

   // Stage ready chain.
   always_comb begin
      stage_ready[LAST] = !valid_ff[LAST] || out_ready;
      for (int s = LAST - 1; s >= 0; s--) begin
         stage_ready[s] = !valid_ff[s] || stage_ready[s + 1];
      end
      valid_src = {valid_ff[LAST-1:0], in_valid};
      tag_in[0] = in_item.tag;
      for (int s = 1; s < STAGES; s++) begin
         tag_in[s] = tag_ff[s - 1];
      end
      for (int s = 0; s < STAGES; s++) begin
         valid_in[s] = stage_ready[s] ? valid_src[s] : valid_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         if (stage_ready[s]) begin
            tag_ff[s] <= tag_in[s];
         end
      end
      if (stage_ready[0]) begin
         s12_ff <= s12_in;
         half_ff <= half_in;
         t1_ff <= in_item.t1;
         t2_ff <= in_item.t2;
      end
      if (stage_ready[1]) begin
         raw_a_ff <= raw_a_in;
         raw_b_ff <= raw_b_in;
         raw_c_ff <= raw_c_in;
      end
      if (stage_ready[2]) begin
         duty_a_ff <= duty_a_in;
         duty_b_ff <= duty_b_in;
         duty_c_ff <= duty_c_in;
      end
   end

   assign in_ready = stage_ready[0];
   assign out_valid = valid_ff[LAST];
   assign out_duty_a = duty_a_ff;
   assign out_duty_b = duty_b_ff;
   assign out_duty_c = duty_c_ff;
   assign out_bridge = tag_ff[LAST].bridge;

endmodule

/* src/space_vector_pwm_duty_generator.sv */
// Pipeline: 5 front stages, 8 divider stages, 3 output stages from an accepted
// request beat to the response beat; one beat per cycle unless rsp_tready stalls.
// The divider retires 4 quotient bits per stage.
// Reset clears all pipeline valid bits and loads supply 12000 and period 4000.
// Requests for motor numbers 0 and 3 are accepted and produce no response.
module space_vector_pwm_duty_generator #(
   parameter int ANGLE_BITS = svpwm_pkg::ANGLE_BITS_DEFAULT,
   parameter int SINE_TABLE_ENTRIES = svpwm_pkg::SINE_ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request: [15:0] voltage_command, [31:16] electrical_angle.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,
   // Request: [1:0] motor_number.
   input  logic [svpwm_pkg::MOTOR_W-1:0]     req_tuser,
   // Response: [15:0] duty_phase_a, [31:16] duty_phase_b, [47:32] duty_phase_c.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [47:0]                       rsp_tdata,
   // Response: [0] bridge_index.
   output logic [0:0]                        rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [svpwm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [svpwm_pkg::CFG_W-1:0]       csr_data
);
   import svpwm_pkg::*;

   logic [CFG_W-1:0] supply_ff, supply_in;
   logic [CFG_W-1:0] period_ff, period_in;

   logic             front_valid, front_ready;
   div_in_type       front_item;
   logic             div_valid, div_ready;
   times_type        div_item;

   logic [DUTY_W-1:0] duty_a, duty_b, duty_c;
   logic              bridge;

   // Configuration writes; a zero supply is stored as one.
   assign csr_ready = 1'b1;

   always_comb begin
      supply_in = supply_ff;
      period_in = period_ff;
      if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_SUPPLY_VOLTAGE: supply_in = (csr_data == '0) ? CFG_W'(1) : csr_data;
            REG_PWM_PERIOD: period_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff <= SUPPLY_RESET;
         period_ff <= PERIOD_RESET;
      end else begin
         supply_ff <= supply_in;
         period_ff <= period_in;
      end
   end

   // Angle, sector, sine table and products.
   svpwm_front #(
      .ANGLE_BITS(ANGLE_BITS),
      .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .in_cmd($signed(req_tdata[15:0])),
      .in_angle(req_tdata[31:16]),
      .in_motor(req_tuser),
      .period(period_ff),
      .out_valid(front_valid),
      .out_ready(front_ready),
      .out_item(front_item)
   );

   // Division by the supply voltage.
   svpwm_div u_div (
      .clock(clock),
      .reset(reset),
      .in_valid(front_valid),
      .in_ready(front_ready),
      .in_item(front_item),
      .divisor(supply_ff),
      .out_valid(div_valid),
      .out_ready(div_ready),
      .out_item(div_item)
   );

   // Zero-time centering, sector mapping and clamping.
   svpwm_mix u_mix (
      .clock(clock),
      .reset(reset),
      .in_valid(div_valid),
      .in_ready(div_ready),
      .in_item(div_item),
      .period(period_ff),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_duty_a(duty_a),
      .out_duty_b(duty_b),
      .out_duty_c(duty_c),
      .out_bridge(bridge)
   );

   assign rsp_tdata = {duty_c, duty_b, duty_a};
   assign rsp_tuser = bridge;

   // Every delivered compare value lies within the timer period.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (duty_a <= period_ff) && (duty_b <= period_ff) &&
                     (duty_c <= period_ff))
      else $error("duty value above the PWM period");

   // The pipeline comes out of reset empty.
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("response beat valid right after reset");

endmodule
